// ===== design/jhsd_pkg.sv =====
// shared types and constants for the jpeg huffman symbol decoder
`timescale 1ns / 1ps

package jhsd_pkg;

  localparam int NUM_TABLES_DEF      = 8;
  localparam int MAX_CODE_LENGTH_DEF = 16;
  localparam int MAX_SYMBOLS_DEF     = 256;

  localparam int COUNT_SLOTS = 16;
  localparam int SLOT_W      = 4;
  localparam int FUNC_W      = 2;
  localparam int SEL_W       = 3;
  localparam int BYTE_W      = 8;
  localparam int PREFIX_W    = 16;
  localparam int LEN_W       = 5;
  localparam int CODE_W      = 17;
  localparam int BASE_W      = 9;
  localparam int OFFSET_W    = 10;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_COUNT  = 2'd0,
    FUNC_SYMBOL = 2'd1,
    FUNC_BIT    = 2'd2
  } func_t;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_t;

  typedef struct packed {
    logic              en;
    logic [SEL_W-1:0]  table_sel;
    logic [SLOT_W-1:0] slot;
    logic [BYTE_W-1:0] value;
  } cnt_wr_t;

  typedef struct packed {
    logic [SEL_W-1:0]  table_sel;
    logic [SLOT_W-1:0] slot;
  } cnt_rd_t;

  typedef struct packed {
    logic busy;
  } tbl_stat_t;

  typedef struct packed {
    logic              en;
    logic [SEL_W-1:0]  table_sel;
    logic [BYTE_W-1:0] pos;
    logic [BYTE_W-1:0] value;
  } sym_wr_t;

  typedef struct packed {
    logic                en;
    logic [SEL_W-1:0]    table_sel;
    logic [OFFSET_W-1:0] offset;
  } sym_lookup_t;

  typedef struct packed {
    logic busy;
    logic valid;
  } sym_stat_t;

endpackage

// ===== design/jhsd_count_table.sv =====
// code count memory, largest code registers and the refresh walk
`timescale 1ns / 1ps

module jhsd_count_table #(
  parameter int NUM_TABLES      = jhsd_pkg::NUM_TABLES_DEF,
  parameter int MAX_CODE_LENGTH = jhsd_pkg::MAX_CODE_LENGTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  jhsd_pkg::cnt_wr_t             wr,
  input  jhsd_pkg::cnt_rd_t             rd,
  input  logic [jhsd_pkg::SEL_W-1:0]    sel_table,
  output logic [jhsd_pkg::BYTE_W-1:0]   rd_count,
  output logic [jhsd_pkg::PREFIX_W-1:0] largest_code,
  output logic [jhsd_pkg::LEN_W-1:0]    largest_length,
  output jhsd_pkg::tbl_stat_t           stat
);

  localparam int TW    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int AW    = TW + jhsd_pkg::SLOT_W;
  localparam int DEPTH = NUM_TABLES * jhsd_pkg::COUNT_SLOTS;

  logic [jhsd_pkg::BYTE_W-1:0]   mem [DEPTH];
  logic [DEPTH-1:0]              entry_ok;
  logic [jhsd_pkg::BYTE_W-1:0]   rd_q;
  logic                          rd_ok;
  logic [AW-1:0]                 wr_addr;
  logic [AW-1:0]                 rd_addr;

  logic [jhsd_pkg::PREFIX_W-1:0] lc_reg [NUM_TABLES];
  logic [jhsd_pkg::LEN_W-1:0]    ll_reg [NUM_TABLES];

  logic                          walk_issue;
  logic                          walk_take;
  logic [jhsd_pkg::SLOT_W-1:0]   issue_slot;
  logic [jhsd_pkg::LEN_W-1:0]    take_len;
  logic [TW-1:0]                 walk_table;
  logic [jhsd_pkg::CODE_W-1:0]   acc_code;
  logic [jhsd_pkg::PREFIX_W-1:0] acc_lc;
  logic [jhsd_pkg::LEN_W-1:0]    acc_ll;

  logic [jhsd_pkg::CODE_W-1:0]   code_sum;
  logic [jhsd_pkg::CODE_W-1:0]   acc_code_next;
  logic [jhsd_pkg::PREFIX_W-1:0] acc_lc_next;
  logic [jhsd_pkg::LEN_W-1:0]    acc_ll_next;
  logic                          walk_last;
  logic                          rd_table_ok;
  logic                          sel_ok;

  assign rd_count    = rd_ok ? rd_q : '0;
  assign wr_addr     = {TW'(wr.table_sel), wr.slot};
  assign rd_table_ok = (int'(rd.table_sel) < NUM_TABLES);
  assign sel_ok      = (int'(sel_table) < NUM_TABLES);
  assign stat.busy   = walk_issue | walk_take;

  always_comb begin
    if (walk_issue) begin
      rd_addr = {walk_table, issue_slot};
    end else if (rd_table_ok) begin
      rd_addr = {TW'(rd.table_sel), rd.slot};
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.value;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_ok <= '0;
      rd_ok    <= 1'b0;
    end else begin
      if (wr.en) begin
        entry_ok[wr_addr] <= 1'b1;
      end
      rd_ok <= entry_ok[rd_addr];
    end
  end

  // running canonical code over the lengths
  always_comb begin
    code_sum      = acc_code + jhsd_pkg::CODE_W'(rd_count);
    acc_code_next = {code_sum[jhsd_pkg::CODE_W-2:0], 1'b0};
    acc_lc_next   = acc_lc;
    acc_ll_next   = acc_ll;
    if (rd_count != '0) begin
      acc_lc_next = jhsd_pkg::PREFIX_W'(code_sum - jhsd_pkg::CODE_W'(1));
      acc_ll_next = take_len;
    end
    walk_last = walk_take && (take_len == jhsd_pkg::LEN_W'(MAX_CODE_LENGTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_issue <= 1'b0;
      walk_take  <= 1'b0;
    end else if (wr.en) begin
      walk_issue <= 1'b1;
      walk_take  <= 1'b0;
    end else begin
      walk_take <= walk_issue;
      if (walk_issue && issue_slot == jhsd_pkg::SLOT_W'(MAX_CODE_LENGTH - 1)) begin
        walk_issue <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      issue_slot <= '0;
      walk_table <= TW'(wr.table_sel);
      acc_code   <= '0;
      acc_lc     <= '0;
      acc_ll     <= '0;
    end else begin
      if (walk_issue) begin
        issue_slot <= issue_slot + jhsd_pkg::SLOT_W'(1);
        take_len   <= jhsd_pkg::LEN_W'(issue_slot) + jhsd_pkg::LEN_W'(1);
      end
      if (walk_take) begin
        acc_code <= acc_code_next;
        acc_lc   <= acc_lc_next;
        acc_ll   <= acc_ll_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TABLES; i++) begin
        lc_reg[i] <= '0;
        ll_reg[i] <= '0;
      end
    end else if (walk_last) begin
      lc_reg[walk_table] <= acc_lc_next;
      ll_reg[walk_table] <= acc_ll_next;
    end
  end

  assign largest_code   = sel_ok ? lc_reg[TW'(sel_table)] : '0;
  assign largest_length = sel_ok ? ll_reg[TW'(sel_table)] : '0;

endmodule

// ===== design/jhsd_symbol_table.sv =====
// symbol memory with position reduction and registered lookup
`timescale 1ns / 1ps

module jhsd_symbol_table #(
  parameter int NUM_TABLES  = jhsd_pkg::NUM_TABLES_DEF,
  parameter int MAX_SYMBOLS = jhsd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  jhsd_pkg::sym_wr_t           wr,
  input  jhsd_pkg::sym_lookup_t       lookup,
  output logic [jhsd_pkg::BYTE_W-1:0] symbol_data,
  output jhsd_pkg::sym_stat_t         stat
);

  localparam int TW       = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int PW       = $clog2(MAX_SYMBOLS);
  localparam int AW       = TW + PW;
  localparam int DEPTH    = NUM_TABLES << PW;
  localparam int OW       = jhsd_pkg::OFFSET_W;
  localparam int RECIP_SH = 20;
  localparam int RECIP    = ((1 << RECIP_SH) + MAX_SYMBOLS - 1) / MAX_SYMBOLS;
  localparam int RW       = $clog2(RECIP + 1);
  localparam int QW       = $clog2((1 << OW) / MAX_SYMBOLS);

  logic [jhsd_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               rd_addr;

  logic                        s1_v;
  logic                        s2_v;
  logic                        s3_v;
  logic [TW-1:0]               s1_t;
  logic [TW-1:0]               s2_t;
  logic [OW-1:0]               s1_x;
  logic [OW-1:0]               s2_x;
  logic [QW-1:0]               s2_q;
  logic [OW+RW-1:0]            prod;
  logic [OW-1:0]               rem;
  logic [jhsd_pkg::BYTE_W-1:0] rd_q;

  assign wr_addr = {TW'(wr.table_sel), PW'(wr.pos)};

  // quotient by reciprocal, exact for offsets below 2^OW
  assign prod    = (OW + RW)'(s1_x) * (OW + RW)'(RECIP);
  assign rem     = s2_x - OW'(OW'(s2_q) * OW'(MAX_SYMBOLS));
  assign rd_addr = {s2_t, PW'(rem)};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= lookup.en;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_t <= TW'(lookup.table_sel);
    s1_x <= lookup.offset;
    s2_t <= s1_t;
    s2_x <= s1_x;
    s2_q <= prod[RECIP_SH +: QW];
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.value;
    end
    if (s2_v) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign symbol_data = rd_q;
  assign stat.busy   = s1_v | s2_v;
  assign stat.valid  = s3_v;

endmodule

// ===== design/jpeg_huffman_symbol_decoder.sv =====
// top level: request control, running prefix and canonical code compare
//
// channel  | direction | handshake          | fields
// request  | in        | start, busy        | func, table_select, table_index,
//          |           |                    | table_value, code_bit
// result   | out       | done (one cycle)   | symbol, status
//
// a code bit that neither ends nor kills the code goes through the count
// memory read in the request cycle and the compare in the next.
// a decoded symbol comes out through the compare, the position
// reduction and the symbol memory read; an error is registered from the compare.
// a count write walks count slots 0 to MAX_CODE_LENGTH-1 of its table.
// reset is synchronous and needs no clearing pass; done is never held off.
`timescale 1ns / 1ps

module jpeg_huffman_symbol_decoder #(
  parameter int NUM_TABLES      = jhsd_pkg::NUM_TABLES_DEF,
  parameter int MAX_CODE_LENGTH = jhsd_pkg::MAX_CODE_LENGTH_DEF,
  parameter int MAX_SYMBOLS     = jhsd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [jhsd_pkg::FUNC_W-1:0] func,
  input  logic [jhsd_pkg::SEL_W-1:0]  table_select,
  input  logic [jhsd_pkg::BYTE_W-1:0] table_index,
  input  logic [jhsd_pkg::BYTE_W-1:0] table_value,
  input  logic                        code_bit,
  output logic                        done,
  output logic [jhsd_pkg::BYTE_W-1:0] symbol,
  output logic                        status
);

  jhsd_pkg::state_t              state;
  jhsd_pkg::state_t              state_next;

  logic [jhsd_pkg::PREFIX_W-1:0] code_prefix;
  logic [jhsd_pkg::PREFIX_W-1:0] code_prefix_next;
  logic [jhsd_pkg::LEN_W-1:0]    prefix_length;
  logic [jhsd_pkg::LEN_W-1:0]    prefix_length_next;
  logic [jhsd_pkg::CODE_W-1:0]   first_code;
  logic [jhsd_pkg::CODE_W-1:0]   first_code_next;
  logic [jhsd_pkg::BASE_W-1:0]   symbol_base;
  logic [jhsd_pkg::BASE_W-1:0]   symbol_base_next;
  logic [jhsd_pkg::SEL_W-1:0]    held_table;
  logic [jhsd_pkg::SEL_W-1:0]    held_table_next;
  logic                          bit_q;
  logic                          bit_q_next;
  logic                          err_q;
  logic                          err_q_next;

  logic                          accept;
  logic [jhsd_pkg::SEL_W-1:0]    t_eff;
  logic                          t_ok;

  jhsd_pkg::cnt_wr_t             cnt_wr;
  jhsd_pkg::cnt_rd_t             cnt_rd;
  jhsd_pkg::tbl_stat_t           tbl_stat;
  jhsd_pkg::sym_wr_t             sym_wr;
  jhsd_pkg::sym_lookup_t         lookup;
  jhsd_pkg::sym_stat_t           sym_stat;

  logic [jhsd_pkg::BYTE_W-1:0]   rd_count;
  logic [jhsd_pkg::PREFIX_W-1:0] largest_code;
  logic [jhsd_pkg::LEN_W-1:0]    largest_length;
  logic [jhsd_pkg::BYTE_W-1:0]   symbol_data;

  logic [jhsd_pkg::LEN_W-1:0]    len;
  logic [jhsd_pkg::PREFIX_W-1:0] prefix;
  logic [jhsd_pkg::CODE_W-1:0]   diff;
  logic [jhsd_pkg::CODE_W-1:0]   fc_sum;
  logic [jhsd_pkg::LEN_W-1:0]    shift;
  logic                          hit;
  logic                          dead;

  jhsd_count_table #(
    .NUM_TABLES      (NUM_TABLES),
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_count (
    .clk            (clk),
    .rst            (rst),
    .wr             (cnt_wr),
    .rd             (cnt_rd),
    .sel_table      (held_table),
    .rd_count       (rd_count),
    .largest_code   (largest_code),
    .largest_length (largest_length),
    .stat           (tbl_stat)
  );

  jhsd_symbol_table #(
    .NUM_TABLES  (NUM_TABLES),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_symbol (
    .clk         (clk),
    .rst         (rst),
    .wr          (sym_wr),
    .lookup      (lookup),
    .symbol_data (symbol_data),
    .stat        (sym_stat)
  );

  assign busy   = (state == jhsd_pkg::ST_EVAL) | tbl_stat.busy | sym_stat.busy;
  assign accept = start & ~busy;
  assign t_eff  = (prefix_length == '0) ? table_select : held_table;
  assign t_ok   = (int'(held_table) < NUM_TABLES);

  assign done   = err_q | sym_stat.valid;
  assign symbol = sym_stat.valid ? symbol_data : '0;
  assign status = err_q;

  // canonical compare for the prefix extended by one bit
  always_comb begin
    len    = prefix_length + jhsd_pkg::LEN_W'(1);
    prefix = {code_prefix[jhsd_pkg::PREFIX_W-2:0], bit_q};
    diff   = jhsd_pkg::CODE_W'(prefix) - first_code;
    hit    = (jhsd_pkg::CODE_W'(prefix) >= first_code)
             && (diff < jhsd_pkg::CODE_W'(rd_count));
    shift  = largest_length - len;
    dead   = (len >= largest_length) || (prefix > (largest_code >> shift));
    fc_sum = first_code + jhsd_pkg::CODE_W'(rd_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jhsd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next         = state;
    code_prefix_next   = code_prefix;
    prefix_length_next = prefix_length;
    first_code_next    = first_code;
    symbol_base_next   = symbol_base;
    held_table_next    = held_table;
    bit_q_next         = bit_q;
    err_q_next         = 1'b0;

    cnt_wr           = '0;
    cnt_wr.table_sel = table_select;
    cnt_wr.slot      = jhsd_pkg::SLOT_W'(table_index);
    cnt_wr.value     = table_value;
    cnt_rd.table_sel = t_eff;
    cnt_rd.slot      = jhsd_pkg::SLOT_W'(prefix_length);
    sym_wr           = '0;
    sym_wr.table_sel = table_select;
    sym_wr.pos       = table_index;
    sym_wr.value     = table_value;
    lookup           = '0;
    lookup.table_sel = held_table;
    lookup.offset    = jhsd_pkg::OFFSET_W'(symbol_base)
                       + jhsd_pkg::OFFSET_W'(diff[jhsd_pkg::BYTE_W-1:0]);

    unique case (state)
      jhsd_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (jhsd_pkg::func_t'(func))
            jhsd_pkg::FUNC_COUNT: begin
              code_prefix_next   = '0;
              prefix_length_next = '0;
              first_code_next    = '0;
              symbol_base_next   = '0;
              cnt_wr.en = (int'(table_select) < NUM_TABLES)
                          && (int'(table_index) < MAX_CODE_LENGTH);
            end
            jhsd_pkg::FUNC_SYMBOL: begin
              code_prefix_next   = '0;
              prefix_length_next = '0;
              first_code_next    = '0;
              symbol_base_next   = '0;
              sym_wr.en = (int'(table_select) < NUM_TABLES)
                          && (int'(table_index) < MAX_SYMBOLS);
            end
            jhsd_pkg::FUNC_BIT: begin
              held_table_next = t_eff;
              bit_q_next      = code_bit;
              state_next      = jhsd_pkg::ST_EVAL;
            end
            default: begin
            end
          endcase
        end
      end
      jhsd_pkg::ST_EVAL: begin
        state_next = jhsd_pkg::ST_IDLE;
        priority if (!t_ok) begin
          err_q_next         = 1'b1;
          code_prefix_next   = '0;
          prefix_length_next = '0;
          first_code_next    = '0;
          symbol_base_next   = '0;
        end else if (hit) begin
          lookup.en          = 1'b1;
          code_prefix_next   = '0;
          prefix_length_next = '0;
          first_code_next    = '0;
          symbol_base_next   = '0;
        end else if (dead) begin
          err_q_next         = 1'b1;
          code_prefix_next   = '0;
          prefix_length_next = '0;
          first_code_next    = '0;
          symbol_base_next   = '0;
        end else begin
          code_prefix_next   = prefix;
          prefix_length_next = len;
          first_code_next    = {fc_sum[jhsd_pkg::CODE_W-2:0], 1'b0};
          symbol_base_next   = symbol_base + jhsd_pkg::BASE_W'(rd_count);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_prefix   <= '0;
      prefix_length <= '0;
      first_code    <= '0;
      symbol_base   <= '0;
      held_table    <= '0;
      err_q         <= 1'b0;
    end else begin
      code_prefix   <= code_prefix_next;
      prefix_length <= prefix_length_next;
      first_code    <= first_code_next;
      symbol_base   <= symbol_base_next;
      held_table    <= held_table_next;
      err_q         <= err_q_next;
    end
  end

  always_ff @(posedge clk) begin
    bit_q <= bit_q_next;
  end

`ifndef SYNTH
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while a request is still in flight");

  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(err_q && sym_stat.valid))
    else $error("error and symbol result in the same cycle");

  a_bit_to_eval: assert property (@(posedge clk) disable iff (rst)
    (accept && func == jhsd_pkg::FUNC_BIT) |=> (state == jhsd_pkg::ST_EVAL))
    else $error("code bit request did not reach compare");

  a_prefix_bound: assert property (@(posedge clk) disable iff (rst)
    (state == jhsd_pkg::ST_EVAL) |-> (prefix_length < jhsd_pkg::LEN_W'(MAX_CODE_LENGTH)))
    else $error("prefix grew past the longest code length");
`endif

endmodule

// ===== verif/jpeg_huffman_symbol_decoder_tb.sv =====
// testbench for the jpeg huffman symbol decoder: random table loads and code bits, checked results
`timescale 1ns / 1ps

module jpeg_huffman_symbol_decoder_tb;
  import jhsd_pkg::*;

  localparam int NT = NUM_TABLES_DEF;
  localparam int MAXLEN = MAX_CODE_LENGTH_DEF;
  localparam int NSYM = MAX_SYMBOLS_DEF;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int STIM_COPY = 0;
  localparam int PRED_COPY = 1;
  localparam int TARGET_REQUESTS = 1900;
  localparam int DRAIN_CYCLES = 60;

  typedef enum int {BIT_PENDING, BIT_SYMBOL, BIT_ERROR} bit_outcome_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SEL_W-1:0]  sel;
    logic [BYTE_W-1:0] index;
    logic [BYTE_W-1:0] value;
    logic              code_bit;
    logic [4:0]        gap;
  } request_t;

  typedef struct packed {
    logic [BYTE_W-1:0] symbol;
    logic              status;
  } decode_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [FUNC_W-1:0] func = '0;
  logic [SEL_W-1:0]  table_select = '0;
  logic [BYTE_W-1:0] table_index = '0;
  logic [BYTE_W-1:0] table_value = '0;
  logic              code_bit = 1'b0;
  logic              done;
  logic [BYTE_W-1:0] symbol;
  logic              status;

  jpeg_huffman_symbol_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .table_select (table_select),
    .table_index  (table_index),
    .table_value  (table_value),
    .code_bit     (code_bit),
    .done         (done),
    .symbol       (symbol),
    .status       (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // two copies of the decoder state: one steers stimulus, one predicts results
  logic [BYTE_W-1:0]   count_tab  [2][NT*COUNT_SLOTS];
  logic [BYTE_W-1:0]   symbol_tab [2][NT*NSYM];
  bit                  symbol_set [NT*NSYM];
  logic [PREFIX_W-1:0] last_code  [2][NT];
  logic [LEN_W-1:0]    last_len   [2][NT];
  logic [PREFIX_W-1:0] run_prefix [2];
  logic [LEN_W-1:0]    run_len    [2];
  logic [CODE_W-1:0]   run_first  [2];
  logic [BASE_W-1:0]   run_base   [2];
  logic [SEL_W-1:0]    run_table  [2];

  request_t       pending_requests[$];
  decode_result_t symbols_due[$];
  int             planned_count = 0;
  int             calm_left = 0;
  bit             failed = 1'b0;
  request_t       offer;
  bit             staged = 1'b0;
  int             gap_left = 0;

  function automatic void clear_run(int m);
    run_prefix[m] = '0;
    run_len[m]    = '0;
    run_first[m]  = '0;
    run_base[m]   = '0;
  endfunction

  function automatic void reset_copy(int m);
    for (int i = 0; i < NT*COUNT_SLOTS; i++) count_tab[m][i] = '0;
    for (int i = 0; i < NT*NSYM; i++) symbol_tab[m][i] = '0;
    for (int i = 0; i < NT; i++) begin
      last_code[m][i] = '0;
      last_len[m][i]  = '0;
    end
    run_table[m] = '0;
    clear_run(m);
  endfunction

  function automatic void refresh_last_code(int m, int t);
    int code, c, lc, ll;
    code = 0;
    lc = 0;
    ll = 0;
    for (int len = 1; len <= MAXLEN; len++) begin
      c = int'(count_tab[m][t*COUNT_SLOTS + len - 1]);
      if (c != 0) begin
        lc = (code + c - 1) & 'hFFFF;
        ll = len;
      end
      code = ((code + c) << 1) & 'h1FFFF;
    end
    last_code[m][t] = lc[PREFIX_W-1:0];
    last_len[m][t]  = ll[LEN_W-1:0];
  endfunction

  function automatic bit_outcome_e step_code_bit(int m, logic [SEL_W-1:0] sel, logic b,
                                                 bit commit, output int t, output int pos);
    int len, prefix, cnt, ll, first;
    bit_outcome_e oc;
    pos = 0;
    t = (run_len[m] == 0) ? int'(sel) : int'(run_table[m]);
    len = int'(run_len[m]) + 1;
    prefix = ((int'(run_prefix[m]) << 1) | int'(b)) & 'hFFFF;
    cnt = (len <= COUNT_SLOTS) ? int'(count_tab[m][t*COUNT_SLOTS + len - 1]) : 0;
    ll = int'(last_len[m][t]);
    first = int'(run_first[m]);
    if (prefix >= first && prefix - first < cnt) begin
      oc = BIT_SYMBOL;
      pos = (int'(run_base[m]) + prefix - first) % NSYM;
    end else if (len >= ll || prefix > (int'(last_code[m][t]) >> (ll - len))) begin
      oc = BIT_ERROR;
    end else begin
      oc = BIT_PENDING;
    end
    if (commit) begin
      if (run_len[m] == 0) run_table[m] = sel;
      if (oc == BIT_PENDING) begin
        run_prefix[m] = prefix[PREFIX_W-1:0];
        run_len[m]    = len[LEN_W-1:0];
        run_first[m]  = CODE_W'(((first + cnt) << 1) & 'h1FFFF);
        run_base[m]   = BASE_W'((int'(run_base[m]) + cnt) & 'h1FF);
      end else begin
        clear_run(m);
      end
    end
    return oc;
  endfunction

  function automatic bit decode_request(int m, request_t r, output decode_result_t res);
    int t, pos;
    bit_outcome_e oc;
    res = '0;
    case (r.func)
      FUNC_COUNT: begin
        clear_run(m);
        if (r.index < MAXLEN) begin
          count_tab[m][r.sel*COUNT_SLOTS + r.index] = r.value;
          refresh_last_code(m, r.sel);
        end
        return 1'b0;
      end
      FUNC_SYMBOL: begin
        clear_run(m);
        symbol_tab[m][r.sel*NSYM + r.index] = r.value;
        if (m == STIM_COPY) symbol_set[r.sel*NSYM + r.index] = 1'b1;
        return 1'b0;
      end
      FUNC_BIT: begin
        oc = step_code_bit(m, r.sel, r.code_bit, 1'b1, t, pos);
        if (oc == BIT_PENDING) return 1'b0;
        if (oc == BIT_SYMBOL) begin
          res.symbol = symbol_tab[m][t*NSYM + pos];
          res.status = 1'b0;
        end else begin
          res.symbol = '0;
          res.status = 1'b1;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void plan_request(logic [FUNC_W-1:0] f, int sel, int index, int value,
                                       logic b);
    request_t r;
    decode_result_t ignored;
    if (calm_left > 0) calm_left--;
    else if ($urandom_range(0, 3) == 0) calm_left = $urandom_range(20, 60);
    r.func     = f;
    r.sel      = sel[SEL_W-1:0];
    r.index    = index[BYTE_W-1:0];
    r.value    = value[BYTE_W-1:0];
    r.code_bit = b;
    r.gap      = (calm_left > 0) ? 5'd0 : 5'($urandom_range(0, 19));
    void'(decode_request(STIM_COPY, r, ignored));
    pending_requests.push_back(r);
    if (f != FUNC_UNUSED) planned_count++;
  endfunction

  // counts that respect the code space, then the symbols in code order
  function automatic void load_table(int t);
    int counts[MAXLEN];
    int open_codes, total, cap, c, hi;
    cap = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 20);
    open_codes = 2;
    total = 0;
    for (int i = 0; i < MAXLEN; i++) begin
      c = 0;
      if (total < cap && open_codes > 0 && $urandom_range(0, 1) == 1) begin
        hi = open_codes;
        if (cap - total < hi) hi = cap - total;
        if (hi > 255) hi = 255;
        c = $urandom_range(0, hi);
      end
      counts[i] = c;
      total += c;
      open_codes = (open_codes - c) * 2;
      if (open_codes > 1000) open_codes = 1000;
    end
    for (int i = 0; i < MAXLEN; i++)
      plan_request(FUNC_COUNT, t, i, counts[i], 1'($urandom_range(0, 1)));
    for (int p = 0; p < total; p++)
      plan_request(FUNC_SYMBOL, t, p, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
  endfunction

  // one code, bit by bit; never lands on a symbol entry that was not written
  function automatic void plan_code();
    int sel, t, pos;
    logic b;
    bit_outcome_e oc;
    sel = $urandom_range(0, NT - 1);
    for (int n = 0; n <= MAXLEN; n++) begin
      b = 1'($urandom_range(0, 1));
      oc = step_code_bit(STIM_COPY, sel[SEL_W-1:0], b, 1'b0, t, pos);
      if (oc == BIT_SYMBOL && !symbol_set[t*NSYM + pos]) begin
        b = ~b;
        oc = step_code_bit(STIM_COPY, sel[SEL_W-1:0], b, 1'b0, t, pos);
      end
      if (oc == BIT_SYMBOL && !symbol_set[t*NSYM + pos]) begin
        plan_request(FUNC_SYMBOL, t, pos, $urandom_range(0, 255), 1'b0);
        return;
      end
      plan_request(FUNC_BIT, sel, $urandom_range(0, 255), $urandom_range(0, 255), b);
      if (oc != BIT_PENDING || $urandom_range(0, 19) == 0) return;
      sel = $urandom_range(0, NT - 1);
    end
  endfunction

  initial begin : stimulus
    int pick;
    reset_copy(STIM_COPY);
    reset_copy(PRED_COPY);

    plan_request(FUNC_BIT, 0, 0, 0, 1'b1);              // empty table
    plan_request(FUNC_UNUSED, 7, 255, 255, 1'b1);
    plan_request(FUNC_COUNT, 7, 255, 255, 1'b0);        // slot out of range
    plan_request(FUNC_COUNT, 7, 0, 1, 1'b0);
    plan_request(FUNC_COUNT, 7, 15, 1, 1'b0);           // one code of full length
    plan_request(FUNC_SYMBOL, 7, 0, 8'h00, 1'b0);
    plan_request(FUNC_SYMBOL, 7, 1, 8'hFF, 1'b0);
    plan_request(FUNC_SYMBOL, 7, 255, 8'h5A, 1'b0);
    plan_request(FUNC_BIT, 7, 0, 0, 1'b0);
    plan_request(FUNC_BIT, 7, 0, 0, 1'b1);
    plan_request(FUNC_BIT, 0, 0, 0, 1'b1);              // latched table, dead path
    plan_request(FUNC_BIT, 7, 0, 0, 1'b1);
    plan_request(FUNC_SYMBOL, 7, 255, 8'hA5, 1'b0);     // load restarts decode
    plan_request(FUNC_BIT, 7, 0, 0, 1'b0);
    plan_request(FUNC_COUNT, 0, 1, 1, 1'b0);
    plan_request(FUNC_SYMBOL, 0, 0, 8'h3C, 1'b0);
    plan_request(FUNC_BIT, 0, 0, 0, 1'b0);
    plan_request(FUNC_BIT, 0, 0, 0, 1'b1);              // longest length reached
    plan_request(FUNC_BIT, 0, 0, 0, 1'b0);
    plan_request(FUNC_BIT, 3, 0, 0, 1'b0);
    plan_request(FUNC_COUNT, 0, 0, 255, 1'b0);          // oversubscribed
    plan_request(FUNC_BIT, 0, 0, 0, 1'b0);

    for (int t = 0; t < NT; t++) load_table(t);
    while (planned_count < TARGET_REQUESTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        load_table($urandom_range(0, NT - 1));
      end else if (pick < 9) begin
        plan_request(FUNC_COUNT, $urandom_range(0, NT - 1),
                     $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255),
                     $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255),
                     1'($urandom_range(0, 1)));
      end else if (pick < 11) begin
        plan_request(FUNC_SYMBOL, $urandom_range(0, NT - 1), $urandom_range(0, 255),
                     $urandom_range(0, 255), 1'($urandom_range(0, 1)));
      end else if (pick < 13) begin
        plan_request(FUNC_UNUSED, $urandom_range(0, NT - 1), $urandom_range(0, 255),
                     $urandom_range(0, 255), 1'($urandom_range(0, 1)));
      end else begin
        plan_code();
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || staged) @(posedge clk);
    while (symbols_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failed) begin
      $display("== FAIL ==");
    end else begin
      $display("== PASS ==");
    end
    $finish;
  end

  always @(posedge clk) begin : request_drive
    decode_result_t due;
    if (rst) begin
      start <= 1'b0;
      staged = 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        if (decode_request(PRED_COPY, offer, due)) symbols_due.push_back(due);
        staged = 1'b0;
      end
      if (!staged && pending_requests.size() != 0) begin
        offer = pending_requests.pop_front();
        gap_left = offer.gap;
        staged = 1'b1;
      end
      if (staged && gap_left == 0) begin
        start        <= 1'b1;
        func         <= offer.func;
        table_select <= offer.sel;
        table_index  <= offer.index;
        table_value  <= offer.value;
        code_bit     <= offer.code_bit;
      end else begin
        start <= 1'b0;
        if (staged) gap_left--;
      end
    end
  end

  always @(posedge clk) begin : result_check
    decode_result_t want;
    if (!rst && done) begin
      if (symbols_due.size() == 0) begin
        $display("%0t: result with none due, symbol %h status %b", $time, symbol, status);
        failed = 1'b1;
      end else begin
        want = symbols_due.pop_front();
        if (symbol !== want.symbol) begin
          $display("%0t: symbol expected %h actual %h", $time, want.symbol, symbol);
          failed = 1'b1;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %b actual %b", $time, want.status, status);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
